// ----- sv/swsolv_pkg.sv -----
// Shared types, constants and tables of the simplex weight solver.
// No dependencies; every other file of the block but swsolv_ifs refers to this package.
package swsolv_pkg;

    localparam int MAX_JOINTS = 16;
    localparam int SWEEPS     = 10;
    localparam int IW         = $clog2(MAX_JOINTS);
    localparam int JW         = $clog2(MAX_JOINTS + 1);
    localparam int SWW        = $clog2(SWEEPS + 1);
    localparam int SUMW       = 17 + IW;

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam longint      EPS_DEN = 64'd10737;
    localparam int          W_SAT   = 1 << 20;

    // Item queue between the front and the back end.
    localparam int QD  = 2;
    localparam int QAW = 1;

    // Shared divider: dividend and divisor widths, iteration counts.
    localparam int DIV_NW = 60;
    localparam int DIV_DW = 40;
    localparam int DIV_CW = $clog2(DIV_NW);
    localparam int DIV_BW = $clog2(DIV_NW + 1);
    localparam logic [DIV_BW-1:0] DIV_SHORT = DIV_BW'(33);
    localparam logic [DIV_BW-1:0] DIV_LONG  = DIV_BW'(60);

    typedef logic [IW-1:0] t_jidx;
    typedef logic [JW-1:0] t_jcnt;
    typedef logic [16:0]   t_share;
    typedef t_share        t_recip_tab [0:MAX_JOINTS];

    // Table of 65536 / m, used for equal shares and for the locked-joint direction.
    // Entry zero holds 65536 and is never used for a division.
    localparam t_recip_tab RECIP = '{
        17'd65536, 17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107,
        17'd10922, 17'd9362,  17'd8192,  17'd7281,  17'd6553,  17'd5957,
        17'd5461,  17'd5041,  17'd4681,  17'd4369,  17'd4096
    };

    typedef struct packed {
        logic               is_solve;
        logic               load_ok;
        t_jidx              idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        t_share             total;
    } t_item;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
        logic [DIV_BW-1:0] bits;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quo;
    } t_div_rsp;

endpackage

// ----- sv/swsolv_ifs.sv -----
// Channel interfaces of the simplex weight solver: input items and result items.
// Stand-alone; no package needed.
interface swsolv_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [3:0]         joint_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [16:0]        total_weight;

    modport source(output valid, command, joint_index, coord_x, coord_y, coord_z,
                   total_weight, input ready);
    modport sink(input valid, command, joint_index, coord_x, coord_y, coord_z,
                 total_weight, output ready);
endinterface

interface swsolv_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  joint_out;
    logic [16:0] weight;
    logic        last;

    modport source(output valid, joint_out, weight, last, input ready);
    modport sink(input valid, joint_out, weight, last, output ready);
endinterface

// ----- sv/swsolv_front.sv -----
// Front end: accepts input transactions, classifies them and queues them.
// Depends on swsolv_pkg and swsolv_in_if.
module swsolv_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    swsolv_in_if.sink           i_item,
    output swsolv_pkg::t_item   o_head,
    output logic                o_head_valid,
    input  logic                i_pop
);
    swsolv_pkg::t_item r_q [swsolv_pkg::QD];
    logic [swsolv_pkg::QAW-1:0] r_wp, r_rp;
    logic [swsolv_pkg::QAW:0]   r_cnt;
    logic                       w_acc;
    swsolv_pkg::t_item          w_new;

    assign i_item.ready = (r_cnt != (swsolv_pkg::QAW+1)'(swsolv_pkg::QD));
    assign w_acc        = i_item.valid && i_item.ready;
    assign o_head       = r_q[r_rp];
    assign o_head_valid = (r_cnt != '0);

    always_comb begin
        w_new.is_solve = i_item.command;
        w_new.load_ok  = (int'(i_item.joint_index) < swsolv_pkg::MAX_JOINTS);
        w_new.idx      = swsolv_pkg::t_jidx'(i_item.joint_index);
        w_new.x        = i_item.coord_x;
        w_new.y        = i_item.coord_y;
        w_new.z        = i_item.coord_z;
        w_new.total    = (i_item.total_weight > swsolv_pkg::ONE_Q16) ?
                         swsolv_pkg::ONE_Q16 : i_item.total_weight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_acc) begin
                r_q[r_wp] <= w_new;
                r_wp      <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (swsolv_pkg::QAW+1)'(w_acc) - (swsolv_pkg::QAW+1)'(i_pop);
        end
    end
endmodule

// ----- sv/swsolv_div.sv -----
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on swsolv_pkg for the request and response structs.
module swsolv_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swsolv_pkg::t_div_req  i_req,
    output swsolv_pkg::t_div_rsp  o_rsp
);
    logic                          r_busy, r_done;
    logic [swsolv_pkg::DIV_NW-1:0] r_num, r_quo;
    logic [swsolv_pkg::DIV_DW-1:0] r_den, r_rem, n_rem;
    logic [swsolv_pkg::DIV_CW-1:0] r_cnt;
    logic [swsolv_pkg::DIV_DW:0]   w_rem2, w_diff;
    logic                          w_ge;

    always_comb begin
        w_rem2 = {r_rem, r_num[r_cnt]};
        w_diff = w_rem2 - {1'b0, r_den};
        w_ge   = (w_rem2 >= {1'b0, r_den});
        n_rem  = w_ge ? w_diff[swsolv_pkg::DIV_DW-1:0] : w_rem2[swsolv_pkg::DIV_DW-1:0];
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= swsolv_pkg::DIV_CW'(i_req.bits - 1'b1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[swsolv_pkg::DIV_NW-2:0], w_ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end
endmodule

// ----- sv/swsolv_back.sv -----
// Back end: position memory, shares, and the coordinate-descent sequencer
// with one shared multiplier; drives the shared divider through its ports. Depends on swsolv_pkg and swsolv_out_if.
module swsolv_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swsolv_pkg::t_item     i_head,
    input  logic                  i_head_valid,
    output logic                  o_pop,
    input  logic [4:0]            i_joint_count,
    output swsolv_pkg::t_div_req  o_div_req,
    input  swsolv_pkg::t_div_rsp  i_div_rsp,
    swsolv_out_if.source          o_result
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MST   = 5'd1;
    localparam logic [4:0] S_MST2  = 5'd2;
    localparam logic [4:0] S_DIR   = 5'd3;
    localparam logic [4:0] S_DIRW  = 5'd4;
    localparam logic [4:0] S_BL_RD = 5'd5;
    localparam logic [4:0] S_BL_M1 = 5'd6;
    localparam logic [4:0] S_BL_M2 = 5'd7;
    localparam logic [4:0] S_BL_A  = 5'd8;
    localparam logic [4:0] S_XS    = 5'd9;
    localparam logic [4:0] S_YS    = 5'd10;
    localparam logic [4:0] S_SQ    = 5'd11;
    localparam logic [4:0] S_XY    = 5'd12;
    localparam logic [4:0] S_NA    = 5'd13;
    localparam logic [4:0] S_CHK   = 5'd14;
    localparam logic [4:0] S_HALVE = 5'd15;
    localparam logic [4:0] S_WCHK  = 5'd16;
    localparam logic [4:0] S_WDIV  = 5'd17;
    localparam logic [4:0] S_UPM   = 5'd18;
    localparam logic [4:0] S_UPA   = 5'd19;
    localparam logic [4:0] S_NCHK  = 5'd20;
    localparam logic [4:0] S_NDIV  = 5'd21;
    localparam logic [4:0] S_NDW   = 5'd22;
    localparam logic [4:0] S_NEXT  = 5'd23;
    localparam logic [4:0] S_OUT   = 5'd24;

    logic [4:0] r_state;

    logic [95:0] mem [swsolv_pkg::MAX_JOINTS];
    logic [95:0] r_rd;
    logic        w_mem_we;

    swsolv_pkg::t_share r_s [swsolv_pkg::MAX_JOINTS];
    logic signed [17:0] r_d [swsolv_pkg::MAX_JOINTS];

    logic signed [31:0] r_tgt [3];
    swsolv_pkg::t_share r_total;
    swsolv_pkg::t_jcnt  r_n;
    swsolv_pkg::t_jidx  r_nm1, r_j, r_k;
    logic [swsolv_pkg::SWW-1:0] r_sweep;
    logic [1:0]         r_c;
    swsolv_pkg::t_share r_other;
    logic signed [55:0] r_acc_d, r_acc_f;
    logic signed [31:0] r_xs, r_fit, r_ys;
    logic signed [63:0] r_den, r_num, r_prod;
    logic signed [21:0] r_w;
    logic [swsolv_pkg::SUMW-1:0] r_sum;

    logic               r_ovalid;
    logic [3:0]         r_ojoint;
    logic [16:0]        r_oweight;
    logic               r_olast;

    swsolv_pkg::t_jcnt  w_n;
    logic signed [31:0] w_pos;
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    logic signed [63:0] w_mag, w_upd;
    swsolv_pkg::t_share w_clamp, w_q17;
    logic [33:0]        w_wt;
    logic               w_jlast;

    function automatic logic signed [63:0] trunc16(input logic signed [63:0] v);
        logic signed [63:0] f;
        f = v + (v[63] ? 64'sd65535 : 64'sd0);
        return f >>> 16;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    always_comb begin
        if (i_joint_count == '0) begin
            w_n = swsolv_pkg::t_jcnt'(1);
        end else if (int'(i_joint_count) > swsolv_pkg::MAX_JOINTS) begin
            w_n = swsolv_pkg::t_jcnt'(swsolv_pkg::MAX_JOINTS);
        end else begin
            w_n = swsolv_pkg::t_jcnt'(i_joint_count);
        end
    end

    assign w_mem_we = (r_state == S_IDLE) && i_head_valid && !i_head.is_solve &&
                      i_head.load_ok;
    assign o_pop    = (r_state == S_IDLE) && i_head_valid;
    assign w_jlast  = (r_j == r_nm1);

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[i_head.idx] <= {i_head.x, i_head.y, i_head.z};
        end
        r_rd <= mem[r_j];
    end

    always_comb begin
        case (r_c)
            2'd0:    w_pos = r_rd[95:64];
            2'd1:    w_pos = r_rd[63:32];
            default: w_pos = r_rd[31:0];
        endcase
    end

    // One shared multiplier; its product is always registered in r_prod.
    always_comb begin
        unique case (r_state)
            S_BL_M1: begin
                w_ma = 33'(w_pos);
                w_mb = 33'(r_d[r_j]);
            end
            S_BL_M2: begin
                w_ma = 33'(w_pos);
                w_mb = $signed({16'b0, r_s[r_j]});
            end
            S_SQ: begin
                w_ma = 33'(r_xs);
                w_mb = 33'(r_xs);
            end
            S_XY: begin
                w_ma = 33'(r_xs);
                w_mb = 33'(r_ys);
            end
            S_UPM: begin
                w_ma = 33'(r_w);
                w_mb = 33'(r_d[r_j]);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod = w_ma * w_mb;
    end

    always_comb begin
        w_mag = r_num[63] ? -r_num : r_num;
        w_upd = 64'($signed({1'b0, r_s[r_j]})) + trunc16(r_prod);
        if (w_upd > 64'sd65536) begin
            w_clamp = swsolv_pkg::ONE_Q16;
        end else if (w_upd[63]) begin
            w_clamp = '0;
        end else begin
            w_clamp = w_upd[16:0];
        end
        w_q17 = (i_div_rsp.quo > swsolv_pkg::DIV_NW'(swsolv_pkg::ONE_Q16)) ?
                swsolv_pkg::ONE_Q16 : i_div_rsp.quo[16:0];
        w_wt  = 34'(r_total) * 34'(r_s[r_j]);
    end

    always_comb begin
        o_div_req       = '0;
        o_div_req.bits  = swsolv_pkg::DIV_SHORT;
        unique case (r_state)
            S_DIR: begin
                o_div_req.start = (r_j != r_k) && (r_other != '0);
                o_div_req.num   = swsolv_pkg::DIV_NW'({r_s[r_j], 16'b0});
                o_div_req.den   = swsolv_pkg::DIV_DW'(r_other);
            end
            S_WCHK: begin
                o_div_req.start = !(w_mag >= (r_den <<< 4));
                o_div_req.num   = swsolv_pkg::DIV_NW'({w_mag[43:0], 16'b0});
                o_div_req.den   = r_den[swsolv_pkg::DIV_DW-1:0];
                o_div_req.bits  = swsolv_pkg::DIV_LONG;
            end
            S_NDIV: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = swsolv_pkg::DIV_NW'({r_s[r_j], 16'b0});
                o_div_req.den   = swsolv_pkg::DIV_DW'(r_sum);
            end
            default: begin
                o_div_req.start = 1'b0;
            end
        endcase
    end

    assign o_result.valid     = r_ovalid;
    assign o_result.joint_out = r_ojoint;
    assign o_result.weight    = r_oweight;
    assign o_result.last      = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_prod <= w_prod[63:0];
            // While emitting, the output state itself decides the valid flag.
            if (o_result.ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_head_valid && i_head.is_solve) begin
                        r_tgt[0] <= i_head.x;
                        r_tgt[1] <= i_head.y;
                        r_tgt[2] <= i_head.z;
                        r_total  <= i_head.total;
                        r_n      <= w_n;
                        r_nm1    <= swsolv_pkg::t_jidx'(w_n - 1'b1);
                        for (int i = 0; i < swsolv_pkg::MAX_JOINTS; i++) begin
                            r_s[i] <= swsolv_pkg::RECIP[w_n];
                        end
                        r_k     <= '0;
                        r_sweep <= '0;
                        r_state <= S_MST;
                    end
                end
                S_MST: begin
                    r_j     <= r_k;
                    r_state <= S_MST2;
                end
                S_MST2: begin
                    r_other <= swsolv_pkg::ONE_Q16 - r_s[r_j];
                    r_j     <= '0;
                    r_state <= S_DIR;
                end
                S_DIR, S_DIRW: begin
                    if (r_state == S_DIR && r_j != r_k && r_other != '0) begin
                        r_state <= S_DIRW;
                    end else if (r_state == S_DIR || i_div_rsp.done) begin
                        if (r_j == r_k) begin
                            r_d[r_j] <= 18'sd65536;
                        end else if (r_state == S_DIR) begin
                            r_d[r_j] <= -$signed({1'b0,
                                swsolv_pkg::RECIP[swsolv_pkg::t_jcnt'(r_n - 1'b1)]});
                        end else begin
                            r_d[r_j] <= -$signed({1'b0, w_q17});
                        end
                        if (w_jlast) begin
                            r_j     <= '0;
                            r_c     <= '0;
                            r_acc_d <= '0;
                            r_acc_f <= '0;
                            r_den   <= '0;
                            r_num   <= '0;
                            r_state <= S_BL_RD;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_DIR;
                        end
                    end
                end
                S_BL_RD: r_state <= S_BL_M1;
                S_BL_M1: r_state <= S_BL_M2;
                S_BL_M2: begin
                    r_acc_d <= r_acc_d + 56'(r_prod);
                    r_state <= S_BL_A;
                end
                S_BL_A: begin
                    r_acc_f <= r_acc_f + 56'(r_prod);
                    if (w_jlast) begin
                        r_state <= S_XS;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_BL_RD;
                    end
                end
                S_XS: begin
                    r_xs    <= sat32(trunc16(64'(r_acc_d)));
                    r_fit   <= sat32(trunc16(64'(r_acc_f)));
                    r_state <= S_YS;
                end
                S_YS: begin
                    r_ys    <= sat32(64'(33'(r_tgt[r_c]) - 33'(r_fit)));
                    r_state <= S_SQ;
                end
                S_SQ: r_state <= S_XY;
                S_XY: begin
                    r_den   <= r_den + (r_prod >>> 2);
                    r_state <= S_NA;
                end
                S_NA: begin
                    r_num <= r_num + ((r_prod + (r_prod[63] ? 64'sd3 : 64'sd0)) >>> 2);
                    if (r_c == 2'd2) begin
                        r_state <= S_CHK;
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_j     <= '0;
                        r_acc_d <= '0;
                        r_acc_f <= '0;
                        r_state <= S_BL_RD;
                    end
                end
                S_CHK: begin
                    r_state <= (r_den < swsolv_pkg::EPS_DEN) ? S_NEXT : S_HALVE;
                end
                S_HALVE: begin
                    if (r_den >= (64'sd1 <<< 40)) begin
                        r_den <= r_den >>> 1;
                        r_num <= (r_num + (r_num[63] ? 64'sd1 : 64'sd0)) >>> 1;
                    end else begin
                        r_state <= S_WCHK;
                    end
                end
                S_WCHK: begin
                    r_j   <= '0;
                    r_sum <= '0;
                    if (w_mag >= (r_den <<< 4)) begin
                        r_w     <= r_num[63] ? -22'(swsolv_pkg::W_SAT) :
                                               22'(swsolv_pkg::W_SAT);
                        r_state <= S_UPM;
                    end else begin
                        r_state <= S_WDIV;
                    end
                end
                S_WDIV: begin
                    if (i_div_rsp.done) begin
                        r_w     <= r_num[63] ? -$signed({1'b0, i_div_rsp.quo[20:0]}) :
                                               $signed({1'b0, i_div_rsp.quo[20:0]});
                        r_state <= S_UPM;
                    end
                end
                S_UPM: r_state <= S_UPA;
                S_UPA: begin
                    r_s[r_j] <= w_clamp;
                    r_sum    <= r_sum + swsolv_pkg::SUMW'(w_clamp);
                    if (w_jlast) begin
                        r_state <= S_NCHK;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_UPM;
                    end
                end
                S_NCHK: begin
                    r_j <= '0;
                    if (r_sum == '0) begin
                        for (int i = 0; i < swsolv_pkg::MAX_JOINTS; i++) begin
                            r_s[i] <= swsolv_pkg::RECIP[r_n];
                        end
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_NDIV;
                    end
                end
                S_NDIV: r_state <= S_NDW;
                S_NDW: begin
                    if (i_div_rsp.done) begin
                        r_s[r_j] <= i_div_rsp.quo[16:0];
                        if (w_jlast) begin
                            r_state <= S_NEXT;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_NDIV;
                        end
                    end
                end
                S_NEXT: begin
                    if (r_k == r_nm1) begin
                        r_k <= '0;
                        if (int'(r_sweep) == swsolv_pkg::SWEEPS - 1) begin
                            r_j     <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_sweep <= r_sweep + 1'b1;
                            r_state <= S_MST;
                        end
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_MST;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_result.ready) begin
                        r_ovalid  <= 1'b1;
                        r_ojoint  <= 4'(r_j);
                        r_oweight <= w_wt[32:16];
                        r_olast   <= w_jlast;
                        if (w_jlast) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- sv/simplex_weight_solver_core.sv -----
// Top level of the simplex weight solver: config register, front end, divider
// and back end. Depends on swsolv_pkg, swsolv_ifs, swsolv_front/div/back.
//
//  channel    | dir | handshake    | carries
//  i_item     | in  | valid/ready  | command, joint_index, coord_x/y/z, total_weight
//  o_result   | out | valid/ready  | joint_out, weight, last
//  i_cfg_*    | in  | write enable | joint_count
//
// A load passes through the queue and the back end into the position memory. A solve with n
// joints runs SWEEPS sweeps of coordinate descent and then emits n results; the shared
// one-bit-per-cycle divider dominates its run time. Reset is synchronous and empties the
// queue and result register. Input and output stall independently through the
// two-entry queue.
module simplex_weight_solver_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    swsolv_in_if.sink     i_item,
    swsolv_out_if.source  o_result,
    input  logic          i_cfg_we,
    input  logic [4:0]    i_cfg_data
);
    logic [4:0]           r_joint_count;
    swsolv_pkg::t_item    w_head;
    logic                 w_head_valid, w_pop;
    swsolv_pkg::t_div_req w_div_req;
    swsolv_pkg::t_div_rsp w_div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joint_count <= 5'd16;
        end else if (i_cfg_we) begin
            r_joint_count <= i_cfg_data;
        end
    end

    swsolv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .i_pop        (w_pop)
    );

    swsolv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    swsolv_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_head_valid  (w_head_valid),
        .o_pop         (w_pop),
        .i_joint_count (r_joint_count),
        .o_div_req     (w_div_req),
        .i_div_rsp     (w_div_rsp),
        .o_result      (o_result)
    );

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while a division is in flight");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_item.ready && !o_result.valid))
        else $error("reset left the queue full or a result pending");
endmodule

// ----- sim/tb.sv -----
// Self-checking bench for simplex_weight_solver_core: joint loads and solves go in,
// per-joint weights come out and are checked against an in-bench fixed-point solver.
// Depends on swsolv_pkg, swsolv_ifs and the solver RTL.
module tb;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;
    localparam longint Q_ONE   = 65536;
    localparam int  WATCHDOG_LIMIT = 1000000;
    localparam int  HOLD_CYCLES    = 8000;

    typedef struct {
        logic               cmd;
        logic [3:0]         idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [16:0]        total;
    } t_joint_cmd;

    typedef struct {
        logic [3:0]  joint;
        logic [16:0] weight;
        logic        last;
    } t_joint_weight;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [4:0] i_cfg_data;

    swsolv_in_if  in_ch();
    swsolv_out_if out_ch();

    simplex_weight_solver_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (in_ch),
        .o_result   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    t_joint_cmd    cmd_queue[$];
    t_joint_weight weight_queue[$];
    int  error_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic hold_req = 1'b0;
    logic hold_ack = 1'b0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    // Solver copy of the block state.
    longint rigid_pos[3][swsolv_pkg::MAX_JOINTS];
    longint share_q[swsolv_pkg::MAX_JOINTS];
    logic [4:0] solve_count_reg = 5'd16;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 5'd0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_LOAD;
        in_ch.joint_index = 4'd0;
        in_ch.coord_x = 32'sd0;
        in_ch.coord_y = 32'sd0;
        in_ch.coord_z = 32'sd0;
        in_ch.total_weight = 17'd0;
        out_ch.ready = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void move_joint(int k, int n, longint tgt[3]);
        longint dir[swsolv_pkg::MAX_JOINTS];
        longint xs, ys, acc_d, acc_s, other, q, den, num, w, s, sum, mag;
        den = 0;
        num = 0;
        sum = 0;
        other = Q_ONE - share_q[k];
        for (int j = 0; j < n; j++) begin
            if (j == k) begin
                dir[j] = Q_ONE;
            end else if (other == 0) begin
                dir[j] = -(Q_ONE / (n - 1));
            end else begin
                q = share_q[j] * Q_ONE / other;
                dir[j] = -(q > Q_ONE ? Q_ONE : q);
            end
        end
        for (int c = 0; c < 3; c++) begin
            acc_d = 0;
            acc_s = 0;
            for (int j = 0; j < n; j++) begin
                acc_d += rigid_pos[c][j] * dir[j];
                acc_s += rigid_pos[c][j] * share_q[j];
            end
            xs = sat32(acc_d / Q_ONE);
            ys = sat32(tgt[c] - sat32(acc_s / Q_ONE));
            den += (xs * xs) / 4;
            num += (xs * ys) / 4;
        end
        if (den < swsolv_pkg::EPS_DEN) return;
        while (den >= (64'sd1 <<< 40)) begin
            den /= 2;
            num /= 2;
        end
        mag = num < 0 ? -num : num;
        if (mag >= den * 16)
            w = num < 0 ? -16 * Q_ONE : 16 * Q_ONE;
        else
            w = num * Q_ONE / den;
        for (int j = 0; j < n; j++) begin
            s = share_q[j] + (w * dir[j]) / Q_ONE;
            if (s > Q_ONE) s = Q_ONE;
            if (s < 0) s = 0;
            share_q[j] = s;
            sum += s;
        end
        if (sum == 0) begin
            for (int j = 0; j < n; j++) share_q[j] = Q_ONE / n;
            return;
        end
        for (int j = 0; j < n; j++) share_q[j] = share_q[j] * Q_ONE / sum;
    endfunction

    // Apply one accepted command; a solve queues its expected joint weights.
    function automatic void apply_joint_cmd(t_joint_cmd c);
        longint tgt[3];
        longint total;
        t_joint_weight r;
        int n;
        if (c.cmd == CMD_LOAD) begin
            rigid_pos[0][c.idx] = longint'(c.x);
            rigid_pos[1][c.idx] = longint'(c.y);
            rigid_pos[2][c.idx] = longint'(c.z);
            return;
        end
        n = int'(solve_count_reg);
        if (n < 1) n = 1;
        if (n > swsolv_pkg::MAX_JOINTS) n = swsolv_pkg::MAX_JOINTS;
        tgt[0] = longint'(c.x);
        tgt[1] = longint'(c.y);
        tgt[2] = longint'(c.z);
        total = longint'(c.total);
        if (total > Q_ONE) total = Q_ONE;
        for (int j = 0; j < n; j++) share_q[j] = Q_ONE / n;
        for (int sw = 0; sw < swsolv_pkg::SWEEPS; sw++)
            for (int k = 0; k < n; k++)
                move_joint(k, n, tgt);
        for (int j = 0; j < n; j++) begin
            r.joint = 4'(j);
            r.weight = 17'((total * share_q[j]) / Q_ONE);
            r.last = (j == n - 1);
            weight_queue.push_back(r);
        end
    endfunction

    // Driver.
    always @(posedge i_clk) begin
        logic next_valid;
        t_joint_cmd c;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            next_valid = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                c.cmd = in_ch.command;
                c.idx = in_ch.joint_index;
                c.x = in_ch.coord_x;
                c.y = in_ch.coord_y;
                c.z = in_ch.coord_z;
                c.total = in_ch.total_weight;
                apply_joint_cmd(c);
                next_valid = 1'b0;
            end
            if (!next_valid && cmd_queue.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                c = cmd_queue.pop_front();
                in_ch.command <= c.cmd;
                in_ch.joint_index <= c.idx;
                in_ch.coord_x <= c.x;
                in_ch.coord_y <= c.y;
                in_ch.coord_z <= c.z;
                in_ch.total_weight <= c.total;
                next_valid = 1'b1;
            end
            in_ch.valid <= next_valid;
        end
    end

    // Monitor and result-side back-pressure.
    always @(posedge i_clk) begin
        t_joint_weight e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (weight_queue.size() == 0) begin
                    $error("unexpected result: joint_out=%0d weight=%0d last=%0d",
                           out_ch.joint_out, out_ch.weight, out_ch.last);
                    error_count++;
                end else begin
                    e = weight_queue.pop_front();
                    if (out_ch.joint_out !== e.joint) begin
                        $error("joint_out: expected %0d, got %0d", e.joint, out_ch.joint_out);
                        error_count++;
                    end
                    if (out_ch.weight !== e.weight) begin
                        $error("weight: expected %0d, got %0d", e.weight, out_ch.weight);
                        error_count++;
                    end
                    if (out_ch.last !== e.last) begin
                        $error("last: expected %0d, got %0d", e.last, out_ch.last);
                        error_count++;
                    end
                end
            end
            if (hold_req != hold_ack) begin
                hold_ack <= hold_req;
                hold_left <= HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(3) == 0)
            return $urandom;
        // Mostly within +-4.0 so that the descent has something to fit.
        return 32'(int'($urandom_range(1 << 19)) - (1 << 18));
    endfunction

    function automatic t_joint_cmd make_cmd(logic cmd, logic [3:0] idx,
                                            logic signed [31:0] x, logic signed [31:0] y,
                                            logic signed [31:0] z, logic [16:0] total);
        t_joint_cmd c;
        c.cmd = cmd;
        c.idx = idx;
        c.x = x;
        c.y = y;
        c.z = z;
        c.total = total;
        return c;
    endfunction

    task automatic wait_idle();
        wait (cmd_queue.size() == 0 && !in_ch.valid && weight_queue.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_joint_count(logic [4:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        solve_count_reg = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [4:0] phase_counts[9];
        logic [16:0] total;
        logic [3:0] ri;
        phase_counts = '{5'd2, 5'd1, 5'd3, 5'd0, 5'd4, 5'd2, 5'd3, 5'd1, 5'd5};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every joint loaded, extreme coordinates among them.
        cmd_queue.push_back(make_cmd(CMD_LOAD, 4'd0, 32'h7fffffff, 32'h80000000, 32'h0, 17'h1ffff));
        cmd_queue.push_back(make_cmd(CMD_LOAD, 4'd15, 32'h80000000, 32'h7fffffff, 32'hffffffff, 17'd0));
        for (int j = 1; j < 15; j++)
            cmd_queue.push_back(make_cmd(CMD_LOAD, 4'(j), rand_coord(), rand_coord(),
                                         rand_coord(), 17'($urandom)));
        // Full joint count at reset value, oversized total weight.
        cmd_queue.push_back(make_cmd(CMD_SOLVE, 4'hf, 32'h7fffffff, 32'h80000000, 32'sd0, 17'h1ffff));
        wait_idle();
        // Count above the joint limit, with joints 0 and 1 reloaded at identical positions.
        write_joint_count(5'd31);
        for (int j = 0; j < 2; j++)
            cmd_queue.push_back(make_cmd(CMD_LOAD, 4'(j), 32'sh10000, 32'sh10000, 32'sh10000, 17'd0));
        cmd_queue.push_back(make_cmd(CMD_SOLVE, 4'd0, 32'sh20000, 32'sh0, 32'sh0, 17'd65536));
        wait_idle();
        write_joint_count(5'd2);
        cmd_queue.push_back(make_cmd(CMD_SOLVE, 4'd0, 32'sh10000, 32'sh10000, 32'sh10000, 17'd40000));
        cmd_queue.push_back(make_cmd(CMD_LOAD, 4'd1, 32'sh30000, -32'sh10000, 32'sh0, 17'd0));
        cmd_queue.push_back(make_cmd(CMD_SOLVE, 4'd0, 32'sh20000, 32'sh0, 32'sh8000, 17'd0));
        cmd_queue.push_back(make_cmd(CMD_SOLVE, 4'd0, 32'h80000000, 32'h7fffffff, 32'h80000000, 17'd65535));
        wait_idle();

        // Random phases: sender-light, receiver-light, then no idling.
        for (int p = 0; p < 9; p++) begin
            case (p / 3)
                0: begin send_idle_pct = 13; recv_idle_pct = 83; end
                1: begin send_idle_pct = 83; recv_idle_pct = 13; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            write_joint_count(phase_counts[p]);
            if (p == 1) hold_req = ~hold_req;
            for (int i = 0; i < 22; i++) begin
                ri = 4'($urandom);
                case ($urandom_range(3))
                    0: total = 17'($urandom);
                    1: total = 17'd65536;
                    default: total = 17'($urandom_range(65536));
                endcase
                if ($urandom_range(4) == 0 || (p == 1 && i < 4))
                    cmd_queue.push_back(make_cmd(CMD_SOLVE, ri, rand_coord(), rand_coord(),
                                                 rand_coord(), total));
                else
                    cmd_queue.push_back(make_cmd(CMD_LOAD, ri, rand_coord(), rand_coord(),
                                                 rand_coord(), total));
            end
            // Sender pause until every weight of this phase has come back.
            wait_idle();
        end

        repeat (200) @(posedge i_clk);
        if (error_count == 0 && weight_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
